FILE: sv/rwr_pkg.sv
// ----------------------------------------------------------------------------
// rwr_pkg
// Shared types and defaults for the reorder window receiver: result kinds,
// controller states and the command/status bundles between control and datapath.
// ----------------------------------------------------------------------------
package rwr_pkg;

   // default sizes
   localparam int DEF_WINDOW_DEPTH = 8;
   localparam int DEF_DATA_WIDTH   = 64;
   localparam int DEF_SEQ_WIDTH    = 16;

   // result kind codes
   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_ACK  = 2'd1,
      KIND_DONE = 2'd2
   } kind_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DRAIN_CHK,
      ST_DRAIN_EMIT,
      ST_FLUSH_CHK,
      ST_FLUSH_EMIT,
      ST_TAIL
   } state_type;

   // source of the next result
   typedef enum logic [1:0] {
      SRC_DRAIN,
      SRC_FLUSH,
      SRC_TAIL
   } out_src_type;

   // controller to datapath
   typedef struct packed {
      logic        capture;
      logic        store;
      logic        rd_en;
      logic        rd_flush;
      logic        out_load;
      out_src_type out_src;
      logic        advance;
      logic        flush_clr;
      logic        cnt_clr;
      logic        cnt_inc;
      logic        set_finished;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic drop;
      logic head_valid;
      logic ptr_valid;
      logic cnt_last;
      logic out_free;
      logic last_pkt;
   } status_type;

endpackage

FILE: sv/rwr_ctrl.sv
// ----------------------------------------------------------------------------
// rwr_ctrl
// Sequencer for one request: classify, store or drop, drain in-order slots,
// flush the window on the final packet, then emit the ack or done result.
// ----------------------------------------------------------------------------
module rwr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  rwr_pkg::status_type status,
   output rwr_pkg::cmd_type    cmd
);
   import rwr_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = status.drop ? ST_IDLE : ST_DRAIN_CHK;
         end
         ST_DRAIN_CHK: begin
            priority if (status.head_valid) state_in = ST_DRAIN_EMIT;
            else if (status.last_pkt)       state_in = ST_FLUSH_CHK;
            else                            state_in = ST_TAIL;
         end
         ST_DRAIN_EMIT: begin
            if (status.out_free) state_in = ST_DRAIN_CHK;
         end
         ST_FLUSH_CHK: begin
            priority if (status.ptr_valid) state_in = ST_FLUSH_EMIT;
            else if (status.cnt_last)      state_in = ST_TAIL;
            else                           state_in = ST_FLUSH_CHK;
         end
         ST_FLUSH_EMIT: begin
            if (status.out_free) state_in = status.cnt_last ? ST_TAIL : ST_FLUSH_CHK;
         end
         ST_TAIL: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      cmd.out_src = SRC_DRAIN;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_CHECK: begin
            cmd.store = ~status.drop;
         end
         ST_DRAIN_CHK: begin
            cmd.rd_en   = status.head_valid;
            cmd.cnt_clr = ~status.head_valid;
         end
         ST_DRAIN_EMIT: begin
            cmd.out_load = status.out_free;
            cmd.out_src  = SRC_DRAIN;
            cmd.advance  = status.out_free;
         end
         ST_FLUSH_CHK: begin
            cmd.rd_en    = status.ptr_valid;
            cmd.rd_flush = 1'b1;
            cmd.cnt_inc  = ~status.ptr_valid;
         end
         ST_FLUSH_EMIT: begin
            cmd.out_load  = status.out_free;
            cmd.out_src   = SRC_FLUSH;
            cmd.flush_clr = status.out_free;
            cmd.cnt_inc   = status.out_free;
         end
         ST_TAIL: begin
            cmd.out_load     = status.out_free;
            cmd.out_src      = SRC_TAIL;
            cmd.set_finished = status.out_free & status.last_pkt;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

FILE: sv/rwr_datapath.sv
// ----------------------------------------------------------------------------
// rwr_datapath
// Window state (base, ring head, valid bits, slot memory), captured request
// and the registered result stage.
// ----------------------------------------------------------------------------
module rwr_datapath #(
   parameter int WINDOW_DEPTH = rwr_pkg::DEF_WINDOW_DEPTH,
   parameter int DATA_WIDTH   = rwr_pkg::DEF_DATA_WIDTH,
   parameter int SEQ_WIDTH    = rwr_pkg::DEF_SEQ_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rwr_pkg::cmd_type      cmd,
   output rwr_pkg::status_type   status,
   input  logic [SEQ_WIDTH-1:0]  in_seq,
   input  logic                  in_chan,
   input  logic                  in_last,
   input  logic [DATA_WIDTH-1:0] in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output rwr_pkg::kind_type     out_kind,
   output logic [SEQ_WIDTH-1:0]  out_seq,
   output logic                  out_chan,
   output logic [DATA_WIDTH-1:0] out_data,
   output logic                  out_last
);
   import rwr_pkg::*;

   localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam logic [IDX_W:0]   DEPTH_X   = (IDX_W + 1)'(WINDOW_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(WINDOW_DEPTH - 1);

   // ring index add with one wrap correction, both operands below the depth
   function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
      logic [IDX_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= DEPTH_X) sum = sum - DEPTH_X;
      return sum[IDX_W-1:0];
   endfunction

   // captured request
   logic [SEQ_WIDTH-1:0]  seq_ff;
   logic                  chan_ff;
   logic                  last_ff;
   logic [DATA_WIDTH-1:0] data_ff;

   // window state
   logic [SEQ_WIDTH-1:0]    base_ff,  base_in;
   logic [IDX_W-1:0]        head_ff,  head_in;
   logic [IDX_W-1:0]        cnt_ff,   cnt_in;
   logic [WINDOW_DEPTH-1:0] valid_ff, valid_in;
   logic                    finished_ff, finished_in;
   logic [DATA_WIDTH-1:0]   mem [WINDOW_DEPTH];
   logic [DATA_WIDTH-1:0]   rd_data_ff;

   // result stage
   logic                  ovalid_ff;
   kind_type              okind_ff;
   logic [SEQ_WIDTH-1:0]  oseq_ff;
   logic                  ochan_ff;
   logic [DATA_WIDTH-1:0] odata_ff;
   logic                  olast_ff;

   logic [SEQ_WIDTH-1:0] diff;
   logic                 stale;
   logic                 in_win;
   logic [IDX_W-1:0]     st_idx;
   logic [IDX_W-1:0]     ptr;
   logic [IDX_W-1:0]     rd_addr;
   logic [IDX_W-1:0]     head_next;

   // classification of the captured packet and ring addresses
   always_comb begin
      diff      = seq_ff - base_ff;
      stale     = seq_ff < base_ff;
      in_win    = 33'(diff) < 33'(WINDOW_DEPTH);
      st_idx    = ring_add(head_ff, IDX_W'(diff));
      ptr       = ring_add(head_ff, cnt_ff);
      rd_addr   = cmd.rd_flush ? ptr : head_ff;
      head_next = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
   end

   // status back to the controller
   always_comb begin
      status.drop       = finished_ff | stale;
      status.head_valid = valid_ff[head_ff];
      status.ptr_valid  = valid_ff[ptr];
      status.cnt_last   = cnt_ff == LAST_IDX;
      status.out_free   = ~ovalid_ff | out_ready;
      status.last_pkt   = last_ff;
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         seq_ff  <= in_seq;
         chan_ff <= in_chan;
         last_ff <= in_last;
         data_ff <= in_data;
      end
   end

   // slot memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (cmd.store && in_win) mem[st_idx] <= data_ff;
      if (cmd.rd_en) rd_data_ff <= mem[rd_addr];
   end

   // window control next values
   always_comb begin
      valid_in    = valid_ff;
      base_in     = base_ff;
      head_in     = head_ff;
      cnt_in      = cnt_ff;
      finished_in = finished_ff | cmd.set_finished;
      if (cmd.store && in_win) valid_in[st_idx] = 1'b1;
      if (cmd.advance) begin
         valid_in[head_ff] = 1'b0;
         head_in           = head_next;
         base_in           = base_ff + 1'b1;
      end
      if (cmd.flush_clr) valid_in[ptr] = 1'b0;
      priority if (cmd.cnt_clr) cnt_in = '0;
      else if (cmd.cnt_inc)     cnt_in = cnt_ff + 1'b1;
   end

   // window control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         base_ff     <= '0;
         head_ff     <= '0;
         cnt_ff      <= '0;
         finished_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         base_ff     <= base_in;
         head_ff     <= head_in;
         cnt_ff      <= cnt_in;
         finished_ff <= finished_in;
      end
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         ovalid_ff <= 1'b1;
      end else if (out_ready) begin
         ovalid_ff <= 1'b0;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         unique case (cmd.out_src)
            SRC_DRAIN: begin
               okind_ff <= KIND_DATA;
               oseq_ff  <= base_ff;
               ochan_ff <= 1'b0;
               odata_ff <= rd_data_ff;
               olast_ff <= 1'b0;
            end
            SRC_FLUSH: begin
               okind_ff <= KIND_DATA;
               oseq_ff  <= base_ff + SEQ_WIDTH'(cnt_ff);
               ochan_ff <= 1'b0;
               odata_ff <= rd_data_ff;
               olast_ff <= 1'b0;
            end
            SRC_TAIL: begin
               okind_ff <= last_ff ? KIND_DONE : KIND_ACK;
               oseq_ff  <= seq_ff;
               ochan_ff <= last_ff ? 1'b0 : chan_ff;
               odata_ff <= '0;
               olast_ff <= 1'b1;
            end
            default: begin
               okind_ff <= KIND_ACK;
               oseq_ff  <= seq_ff;
               ochan_ff <= chan_ff;
               odata_ff <= '0;
               olast_ff <= 1'b1;
            end
         endcase
      end
   end

   assign out_valid = ovalid_ff;
   assign out_kind  = okind_ff;
   assign out_seq   = oseq_ff;
   assign out_chan  = ochan_ff;
   assign out_data  = odata_ff;
   assign out_last  = olast_ff;

endmodule

FILE: sv/reorder_window_receiver.sv
// ----------------------------------------------------------------------------
// reorder_window_receiver
// Selective-repeat receive window: stores out-of-order packets, delivers them
// in order, acknowledges packets that are not dropped, flushes on the final one.
// ----------------------------------------------------------------------------
// usage:
//   req_* takes data packets: tdata = {payload, seq_no}, tuser = channel,
//   tlast = final packet of the transfer.
//   rsp_* gives results: tdata = {out_data, out_seq}, tuser = {out_channel,
//   kind}, tlast = final result of the request that caused it.
//   a request yields no result (stale or after done), or zero or more in-order
//   deliveries followed by one ack, or for the final packet the deliveries,
//   the remaining occupied window slots in order and one done.
// request flow:
//   a request is taken, classified and stored in the next cycle, then the
//   head slot is checked and the ack or done is loaded; a stale or ignored
//   request ends after the classify step; each delivered slot adds one
//   registered slot-memory read and one result load; the final flush walks
//   all window slots, checking each and loading a result for each full one.
// reset: window base to zero, all slots empty, transfer open; no clearing pass.
// stall: results sit in a one-deep output register; while rsp_tready is low
//   the sequencer holds at its next result and stops taking requests after it.
// ----------------------------------------------------------------------------
module reorder_window_receiver #(
   parameter int WINDOW_DEPTH = rwr_pkg::DEF_WINDOW_DEPTH,
   parameter int DATA_WIDTH   = rwr_pkg::DEF_DATA_WIDTH,
   parameter int SEQ_WIDTH    = rwr_pkg::DEF_SEQ_WIDTH,
   parameter int TDATA_WIDTH  = ((SEQ_WIDTH + DATA_WIDTH + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [TDATA_WIDTH-1:0] req_tdata,   // seq_no, payload
   input  logic [0:0]             req_tuser,   // channel
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [TDATA_WIDTH-1:0] rsp_tdata,   // out_seq, out_data
   output logic [7:0]             rsp_tuser,   // kind, out_channel
   output logic                   rsp_tlast
);
   import rwr_pkg::*;

   cmd_type               cmd;
   status_type            status;
   kind_type              out_kind;
   logic [SEQ_WIDTH-1:0]  out_seq;
   logic                  out_chan;
   logic [DATA_WIDTH-1:0] out_data;

   // sequencer
   rwr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // window storage and result stage
   rwr_datapath #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .DATA_WIDTH   (DATA_WIDTH),
      .SEQ_WIDTH    (SEQ_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .in_seq    (req_tdata[SEQ_WIDTH-1:0]),
      .in_chan   (req_tuser[0]),
      .in_last   (req_tlast),
      .in_data   (req_tdata[SEQ_WIDTH+DATA_WIDTH-1:SEQ_WIDTH]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_kind  (out_kind),
      .out_seq   (out_seq),
      .out_chan  (out_chan),
      .out_data  (out_data),
      .out_last  (rsp_tlast)
   );

   // result packing, zero fill to whole bytes
   assign rsp_tdata = TDATA_WIDTH'({out_data, out_seq});
   assign rsp_tuser = 8'({out_chan, out_kind});

endmodule
